[src/popq_pkg.sv]
// Shared types and constants for the priority-ordered process queue.
package popq_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT = 32;
   localparam int PID_BITS         = 4;
   localparam int KEY_PORT_BITS    = 32;
   localparam int COUNT_OUT_BITS   = 5;
   localparam int CMDQ_DEPTH       = 2;
   localparam int CMDQ_PTR_BITS    = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_BITS    = $clog2(CMDQ_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_INSERT       = 2'd0,
      OP_REMOVE_FIRST = 2'd1,
      OP_REMOVE_LAST  = 2'd2,
      OP_REMOVE_PID   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_EVAL = 1'b1
   } back_state_type;

   // key is held with its sign bit flipped so unsigned order equals signed order
   typedef struct packed {
      op_type                    op;
      logic [PID_BITS-1:0]       pid;
      logic [KEY_PORT_BITS-1:0]  key;
   } cmd_type;

   // handshake between the command queue and the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmdq_head_type;

endpackage

[src/popq_if.sv]
// Request and response channel interfaces.
interface popq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           operation;
   logic [popq_pkg::PID_BITS-1:0]        pid;
   logic signed [popq_pkg::KEY_PORT_BITS-1:0] key;

   modport source (output valid, output operation, output pid, output key, input ready);
   modport sink   (input valid, input operation, input pid, input key, output ready);
endinterface

interface popq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [popq_pkg::PID_BITS-1:0]         result_pid;
   logic [1:0]                            status;
   logic [popq_pkg::COUNT_OUT_BITS-1:0]   count;
   logic                                  is_empty;
   logic                                  is_full;

   modport source (output valid, output result_pid, output status, output count,
                   output is_empty, output is_full, input ready);
   modport sink   (input valid, input result_pid, input status, input count,
                   input is_empty, input is_full, output ready);
endinterface

[src/popq_front.sv]
// Front end: accepts requests and turns them into normalized commands.
module popq_front #(
   parameter int KEY_BITS = popq_pkg::KEY_BITS_DEFAULT
) (
   popq_req_if.sink           req_bus,
   input  logic               cmdq_full,
   output logic               push,
   output popq_pkg::cmd_type  push_cmd
);

   logic [KEY_BITS-1:0] key_flip;

   // flip the sign bit so the cells can compare keys unsigned
   assign key_flip = req_bus.key[KEY_BITS-1:0] ^ {1'b1, {(KEY_BITS-1){1'b0}}};

   assign req_bus.ready = !cmdq_full;
   assign push          = req_bus.valid && !cmdq_full;

   always_comb begin
      push_cmd.op  = popq_pkg::op_type'(req_bus.operation);
      push_cmd.pid = req_bus.pid;
      push_cmd.key = popq_pkg::KEY_PORT_BITS'(key_flip);
   end

endmodule

[src/popq_cmdq.sv]
// Short command queue between the front end and the back end.
module popq_cmdq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  popq_pkg::cmd_type        push_cmd,
   output logic                     full,
   input  logic                     pop,
   output popq_pkg::cmdq_head_type  head
);

   popq_pkg::cmd_type                        slot_ff [popq_pkg::CMDQ_DEPTH];
   logic [popq_pkg::CMDQ_PTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [popq_pkg::CMDQ_PTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [popq_pkg::CMDQ_CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic                                     do_pop;

   assign full       = (cnt_ff == popq_pkg::CMDQ_CNT_BITS'(popq_pkg::CMDQ_DEPTH));
   assign head.valid = (cnt_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) full |-> !push;
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("command queue overflow");

endmodule

[src/popq_back.sv]
// Back end: sorted cell array that executes commands and holds the result.
module popq_back #(
   parameter int DEPTH    = popq_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = popq_pkg::KEY_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  popq_pkg::cmdq_head_type  head,
   output logic                     pop,
   popq_rsp_if.source               rsp_bus
);

   localparam int CW = $clog2(DEPTH + 1);

   popq_pkg::back_state_type           state_ff, state_in;
   logic [popq_pkg::PID_BITS-1:0]      pid_ff [DEPTH];
   logic [popq_pkg::PID_BITS-1:0]      pid_in [DEPTH];
   logic [KEY_BITS-1:0]                key_ff [DEPTH];
   logic [KEY_BITS-1:0]                key_in [DEPTH];
   logic [CW-1:0]                      count_ff, count_in;
   popq_pkg::cmd_type                  cmd_ff;
   logic [DEPTH-1:0]                   ge_ff, ge_in;
   logic [DEPTH-1:0]                   match_ff, match_in;
   logic [popq_pkg::PID_BITS-1:0]      tail_ff, tail_in;
   logic [DEPTH-1:0]                   ge_prev;
   logic [DEPTH-1:0]                   prefix_match;
   logic [DEPTH-1:0]                   shift_up;
   logic [CW-1:0]                      count_last;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [popq_pkg::PID_BITS-1:0]      rsp_pid_ff, rsp_pid_in;
   popq_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                      rsp_count_ff;

   logic                               out_free;
   logic                               commit;
   logic                               q_empty;
   logic                               q_full;
   logic                               do_insert;
   logic                               do_remove;

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign q_empty    = (count_ff == '0);
   assign q_full     = (count_ff == CW'(DEPTH));
   assign count_last = count_ff - 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         popq_pkg::BACK_IDLE: if (head.valid) state_in = popq_pkg::BACK_EVAL;
         popq_pkg::BACK_EVAL: if (out_free)   state_in = popq_pkg::BACK_IDLE;
         default:             state_in = popq_pkg::BACK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop    = 1'b0;
      commit = 1'b0;
      unique case (state_ff)
         popq_pkg::BACK_IDLE: pop    = head.valid;
         popq_pkg::BACK_EVAL: commit = out_free;
         default: begin
            pop    = 1'b0;
            commit = 1'b0;
         end
      endcase
   end

   // compare stage: every cell against the command at the queue head
   always_comb begin
      tail_in = '0;
      for (int i = 0; i < DEPTH; i++) begin
         ge_in[i]    = (CW'(i) < count_ff) &&
                       (key_ff[i] >= head.cmd.key[KEY_BITS-1:0]);
         match_in[i] = (CW'(i) < count_ff) && (pid_ff[i] == head.cmd.pid);
         if (CW'(i) == count_last) begin
            tail_in = tail_in | pid_ff[i];
         end
      end
   end

   // first pid match and everything behind it moves toward the head
   always_comb begin
      logic run;
      run = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         run             = run | match_ff[i];
         prefix_match[i] = run;
      end
   end

   assign ge_prev = {ge_ff[DEPTH-2:0], 1'b1};

   always_comb begin
      do_insert     = 1'b0;
      do_remove     = 1'b0;
      shift_up      = '0;
      rsp_pid_in    = '0;
      rsp_status_in = popq_pkg::ST_OK;
      if (cmd_ff.op == popq_pkg::OP_INSERT) begin
         if (q_full) begin
            rsp_status_in = popq_pkg::ST_FULL;
         end else begin
            do_insert  = 1'b1;
            rsp_pid_in = cmd_ff.pid;
         end
      end else if (q_empty) begin
         rsp_status_in = popq_pkg::ST_EMPTY;
      end else begin
         unique case (cmd_ff.op)
            popq_pkg::OP_REMOVE_FIRST: begin
               do_remove  = 1'b1;
               shift_up   = '1;
               rsp_pid_in = pid_ff[0];
            end
            popq_pkg::OP_REMOVE_LAST: begin
               do_remove  = 1'b1;
               rsp_pid_in = tail_ff;
            end
            popq_pkg::OP_REMOVE_PID: begin
               if (|match_ff) begin
                  do_remove  = 1'b1;
                  shift_up   = prefix_match;
                  rsp_pid_in = cmd_ff.pid;
               end else begin
                  rsp_status_in = popq_pkg::ST_NOTFOUND;
               end
            end
            default: begin
               rsp_status_in = popq_pkg::ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (commit && do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (commit && do_remove) begin
         count_in = count_last;
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [popq_pkg::PID_BITS-1:0] pid_lo, pid_hi;
         logic [KEY_BITS-1:0]           key_lo, key_hi;

         if (g == 0) begin : g_first
            assign pid_lo = cmd_ff.pid;
            assign key_lo = cmd_ff.key[KEY_BITS-1:0];
         end else begin : g_rest
            assign pid_lo = pid_ff[g-1];
            assign key_lo = key_ff[g-1];
         end

         if (g == DEPTH - 1) begin : g_last
            assign pid_hi = pid_ff[g];
            assign key_hi = key_ff[g];
         end else begin : g_inner
            assign pid_hi = pid_ff[g+1];
            assign key_hi = key_ff[g+1];
         end

         always_comb begin
            pid_in[g] = pid_ff[g];
            key_in[g] = key_ff[g];
            if (do_insert) begin
               // hold entries with key >= new; first cell behind them takes the new entry
               if (!ge_ff[g] && ge_prev[g]) begin
                  pid_in[g] = cmd_ff.pid;
                  key_in[g] = cmd_ff.key[KEY_BITS-1:0];
               end else if (!ge_ff[g]) begin
                  pid_in[g] = pid_lo;
                  key_in[g] = key_lo;
               end
            end else if (shift_up[g]) begin
               pid_in[g] = pid_hi;
               key_in[g] = key_hi;
            end
         end
      end
   endgenerate

   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= popq_pkg::BACK_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff   <= head.cmd;
         ge_ff    <= ge_in;
         match_ff <= match_in;
         tail_ff  <= tail_in;
      end
      if (commit) begin
         for (int i = 0; i < DEPTH; i++) begin
            pid_ff[i] <= pid_in[i];
            key_ff[i] <= key_in[i];
         end
         rsp_pid_ff    <= rsp_pid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.result_pid = rsp_pid_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.count      = popq_pkg::COUNT_OUT_BITS'(rsp_count_ff);
   assign rsp_bus.is_empty   = (rsp_count_ff == '0);
   assign rsp_bus.is_full    = (rsp_count_ff == CW'(DEPTH));

   property p_count_bound;
      @(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH);
   endproperty
   a_count_bound: assert property (p_count_bound) else $error("count above depth");

   // cells are sorted, so the key >= new set must be a run from the head
   property p_sorted_prefix;
      @(posedge clock) disable iff (reset)
         state_ff == popq_pkg::BACK_EVAL |-> $onehot0(ge_ff + DEPTH'(1));
   endproperty
   a_sorted_prefix: assert property (p_sorted_prefix) else $error("cell order broken");

   property p_full_status;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && rsp_status_ff == popq_pkg::ST_FULL |-> rsp_bus.is_full;
   endproperty
   a_full_status: assert property (p_full_status) else $error("full status without full");

   property p_empty_status;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff && rsp_status_ff == popq_pkg::ST_EMPTY |-> rsp_bus.is_empty;
   endproperty
   a_empty_status: assert property (p_empty_status) else $error("empty status with entries");

   property p_hold_when_blocked;
      @(posedge clock) disable iff (reset)
         state_ff == popq_pkg::BACK_EVAL && !out_free |=> state_ff == popq_pkg::BACK_EVAL;
   endproperty
   a_hold_when_blocked: assert property (p_hold_when_blocked)
      else $error("command dropped while result blocked");

endmodule

[src/priority_ordered_process_queue.sv]
// Top level of the priority-ordered process queue.
//
//  channel   direction  payload
//  req_bus   in         operation[1:0], pid[3:0], key[31:0] signed
//  rsp_bus   out        result_pid[3:0], status[1:0], count[4:0], is_empty, is_full
//
// In the back end each request is first compared against every cell, then
// the cell array shifts and the result register loads once the result is free.
// The back end takes no new request until the previous one has committed.
// Reset is synchronous; it empties the queue, the command queue and the result.
// While rsp_bus.ready is low the result holds and the two-entry command
// queue keeps taking requests until it fills.
module priority_ordered_process_queue #(
   parameter int DEPTH    = popq_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = popq_pkg::KEY_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   popq_req_if.sink    req_bus,
   popq_rsp_if.source  rsp_bus
);

   logic                     cmdq_full;
   logic                     push;
   popq_pkg::cmd_type        push_cmd;
   logic                     pop;
   popq_pkg::cmdq_head_type  head;

   popq_front #(
      .KEY_BITS (KEY_BITS)
   ) u_front (
      .req_bus   (req_bus),
      .cmdq_full (cmdq_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   popq_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (cmdq_full),
      .pop      (pop),
      .head     (head)
   );

   popq_back #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

[verif/priority_ordered_process_queue_tb.sv]
// Self-checking testbench for the priority-ordered process queue.

class popq_order_tracker;
   typedef struct {
      logic [popq_pkg::PID_BITS-1:0]       pid;
      popq_pkg::status_type                status;
      logic [popq_pkg::COUNT_OUT_BITS-1:0] count;
      logic                                is_empty;
      logic                                is_full;
   } rsp_item_type;

   logic [popq_pkg::PID_BITS-1:0]       held_pid[popq_pkg::DEPTH_DEFAULT];
   logic signed [popq_pkg::KEY_PORT_BITS-1:0] held_key[popq_pkg::DEPTH_DEFAULT];
   int                                  held;
   rsp_item_type                        pending_results[$];
   int                                  errors;

   function new();
      held   = 0;
      errors = 0;
   endfunction

   function int pending();
      return pending_results.size();
   endfunction

   // pick a pid that is in the queue, or any pid when it is empty
   function logic [popq_pkg::PID_BITS-1:0] queued_pid();
      if (held == 0) return popq_pkg::PID_BITS'($urandom_range(0, 15));
      return held_pid[$urandom_range(0, held - 1)];
   endfunction

   function logic [popq_pkg::PID_BITS-1:0] unlink(int pos);
      logic [popq_pkg::PID_BITS-1:0] p;
      p = held_pid[pos];
      for (int i = pos; i + 1 < held; i++) begin
         held_pid[i] = held_pid[i + 1];
         held_key[i] = held_key[i + 1];
      end
      held--;
      return p;
   endfunction

   function void note_request(popq_pkg::op_type op, logic [popq_pkg::PID_BITS-1:0] pid,
                              logic signed [popq_pkg::KEY_PORT_BITS-1:0] key);
      rsp_item_type r;
      int           pos;
      r.pid    = '0;
      r.status = popq_pkg::ST_OK;
      if (op == popq_pkg::OP_INSERT) begin
         if (held >= popq_pkg::DEPTH_DEFAULT) begin
            r.status = popq_pkg::ST_FULL;
         end else begin
            // equal keys keep arrival order: go after every key >= the new one
            pos = 0;
            while (pos < held && held_key[pos] >= key) pos++;
            for (int i = held; i > pos; i--) begin
               held_pid[i] = held_pid[i - 1];
               held_key[i] = held_key[i - 1];
            end
            held_pid[pos] = pid;
            held_key[pos] = key;
            held++;
            r.pid = pid;
         end
      end else if (held == 0) begin
         r.status = popq_pkg::ST_EMPTY;
      end else begin
         case (op)
            popq_pkg::OP_REMOVE_FIRST: r.pid = unlink(0);
            popq_pkg::OP_REMOVE_LAST:  r.pid = unlink(held - 1);
            default: begin
               pos = 0;
               while (pos < held && held_pid[pos] != pid) pos++;
               if (pos < held) r.pid = unlink(pos);
               else r.status = popq_pkg::ST_NOTFOUND;
            end
         endcase
      end
      r.count    = popq_pkg::COUNT_OUT_BITS'(held);
      r.is_empty = (held == 0);
      r.is_full  = (held >= popq_pkg::DEPTH_DEFAULT);
      pending_results.push_back(r);
   endfunction

   function void check_response(logic [popq_pkg::PID_BITS-1:0] pid, logic [1:0] status,
                                logic [popq_pkg::COUNT_OUT_BITS-1:0] count,
                                logic is_empty, logic is_full);
      rsp_item_type e;
      if (pending_results.size() == 0) begin
         $display("%0t: response with nothing outstanding: pid %0d status %0d count %0d",
                  $time, pid, status, count);
         errors++;
         return;
      end
      e = pending_results.pop_front();
      if (pid !== e.pid) begin
         $display("%0t: result_pid expected %0d actual %0d", $time, e.pid, pid);
         errors++;
      end
      if (status !== e.status) begin
         $display("%0t: status expected %0d actual %0d", $time, e.status, status);
         errors++;
      end
      if (count !== e.count) begin
         $display("%0t: count expected %0d actual %0d", $time, e.count, count);
         errors++;
      end
      if (is_empty !== e.is_empty) begin
         $display("%0t: is_empty expected %0b actual %0b", $time, e.is_empty, is_empty);
         errors++;
      end
      if (is_full !== e.is_full) begin
         $display("%0t: is_full expected %0b actual %0b", $time, e.is_full, is_full);
         errors++;
      end
   endfunction
endclass

module priority_ordered_process_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1350;
   localparam int QUIET_ITEMS  = 150;
   localparam int STALL_LIMIT  = 3000;

   logic clock;
   logic reset;
   bit   idling_on;
   int   ready_hold;
   int   quiet_cycles;

   popq_order_tracker tracker = new();

   popq_req_if req_bus();
   popq_rsp_if rsp_bus();

   priority_ordered_process_queue u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // check completed responses and throttle ready
   always @(posedge clock) begin
      if (reset) begin
         ready_hold = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_response(rsp_bus.result_pid, rsp_bus.status, rsp_bus.count,
                                   rsp_bus.is_empty, rsp_bus.is_full);
         if (ready_hold > 0) begin
            ready_hold--;
            rsp_bus.ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            ready_hold = $urandom_range(1, 19) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // end the run if no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic send(popq_pkg::op_type op, logic [popq_pkg::PID_BITS-1:0] pid,
                       logic signed [popq_pkg::KEY_PORT_BITS-1:0] key);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.pid       <= pid;
      req_bus.key       <= key;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      tracker.note_request(op, pid, key);
   endtask

   task automatic wait_drained();
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic random_item(int insert_weight);
      popq_pkg::op_type                          op;
      logic [popq_pkg::PID_BITS-1:0]             pid;
      logic signed [popq_pkg::KEY_PORT_BITS-1:0] key;
      int                                        v;
      if ($urandom_range(0, 99) < insert_weight) op = popq_pkg::OP_INSERT;
      else op = popq_pkg::op_type'($urandom_range(1, 3));
      pid = popq_pkg::PID_BITS'($urandom_range(0, 15));
      if (op == popq_pkg::OP_REMOVE_PID && $urandom_range(0, 3) != 0)
         pid = tracker.queued_pid();
      case ($urandom_range(0, 3))
         0: begin
            // narrow range to force ties
            v   = int'($urandom_range(0, 8)) - 4;
            key = v;
         end
         1: begin
            case ($urandom_range(0, 3))
               0: key = 32'sh8000_0000;
               1: key = 32'sh7fff_ffff;
               2: key = 0;
               default: key = -1;
            endcase
         end
         default: key = $urandom;
      endcase
      send(op, pid, key);
   endtask

   initial begin
      int done;
      int phase_len;
      int weight;
      reset             <= 1'b1;
      idling_on         = 1'b0;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= popq_pkg::OP_INSERT;
      req_bus.pid       <= '0;
      req_bus.key       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // removes on an empty queue
      send(popq_pkg::OP_REMOVE_FIRST, 4'd0, 0);
      send(popq_pkg::OP_REMOVE_LAST, 4'd0, 0);
      send(popq_pkg::OP_REMOVE_PID, 4'd15, 0);
      // key extremes, ties and a duplicate pid
      send(popq_pkg::OP_INSERT, 4'd0, 0);
      send(popq_pkg::OP_INSERT, 4'd15, 32'sh7fff_ffff);
      send(popq_pkg::OP_INSERT, 4'd5, 32'sh8000_0000);
      send(popq_pkg::OP_INSERT, 4'd9, 0);
      send(popq_pkg::OP_INSERT, 4'd10, -1);
      send(popq_pkg::OP_INSERT, 4'd5, 0);
      send(popq_pkg::OP_INSERT, 4'd3, 32'sh8000_0000);
      // pid not present, then duplicate pid resolved nearest the head
      send(popq_pkg::OP_REMOVE_PID, 4'd7, 0);
      send(popq_pkg::OP_REMOVE_PID, 4'd5, 32'sh7fff_ffff);
      send(popq_pkg::OP_REMOVE_FIRST, 4'd0, 0);
      send(popq_pkg::OP_REMOVE_LAST, 4'd0, 0);
      send(popq_pkg::OP_REMOVE_LAST, 4'd0, 0);
      send(popq_pkg::OP_REMOVE_PID, 4'd9, 0);
      send(popq_pkg::OP_REMOVE_FIRST, 4'd0, 0);
      send(popq_pkg::OP_REMOVE_FIRST, 4'd0, 0);
      send(popq_pkg::OP_REMOVE_PID, 4'd0, 0);

      idling_on = 1'b1;
      done      = 0;
      while (done < RANDOM_ITEMS) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: weight = 15;
            1: weight = 50;
            default: weight = 90;
         endcase
         for (int i = 0; i < phase_len && done < RANDOM_ITEMS; i++) begin
            if (done == RANDOM_ITEMS / 2) begin
               // hold the sender until every outstanding response is back
               req_bus.valid <= 1'b0;
               wait_drained();
            end
            if (done == RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
            random_item(weight);
            done++;
         end
      end
      req_bus.valid <= 1'b0;

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
